/* rtl/core/oal_pkg.sv */
// Shared types and constants for the ordered array list.
// No dependencies; used by ordered_array_list.
`timescale 1ns / 1ps

package oal_pkg;

  localparam int unsigned POS_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned STS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

/* rtl/core/ordered_array_list.sv */
// Ordered array list of signed 32-bit values held in one RAM with a length count.
// Depends on oal_pkg and oal_ram.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_ready_o | command_i, position_i, value_i
//  out     | output    | out_valid_o/out_ready_i | status_o, found_position_o, count_o
//
// One word in gives one word out; the single read port of the entry RAM moves or compares
// one entry per cycle. Reset clears the length and the control state; the RAM needs no
// clearing, since only entries below the length are ever read. A stalled output holds its
// word while the next command runs; that result waits in its last state.

module ordered_array_list #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oal_pkg::CMD_W-1:0]       command_i,
  input  logic [oal_pkg::POS_W-1:0]       position_i,
  input  logic signed [oal_pkg::VAL_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [oal_pkg::STS_W-1:0]       status_o,
  output logic [oal_pkg::POS_W-1:0]       found_position_o,
  output logic [oal_pkg::POS_W-1:0]       count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  // compare width: wide enough for position, length and length + 1
  localparam int unsigned CW = ((LW > oal_pkg::POS_W) ? LW : oal_pkg::POS_W) + 1;

  oal_pkg::state_e  state_q, state_d;
  oal_pkg::cmd_e    cmd_q, cmd_d;
  oal_pkg::status_e sts_q, sts_d;

  logic [LW-1:0]             len_q, len_d;
  logic [LW-1:0]             rem_q, rem_d;        // reads still to issue
  logic                      rd_pend_q, rd_pend_d; // read data arrives this cycle
  logic [AW-1:0]             rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]             pend_addr_q, pend_addr_d; // write target or scanned index
  logic [AW-1:0]             put_addr_q, put_addr_d;
  logic [oal_pkg::VAL_W-1:0] val_q, val_d;
  logic [oal_pkg::POS_W-1:0] fnd_q, fnd_d;

  logic                      out_valid_q, out_valid_d;
  logic [oal_pkg::STS_W-1:0] out_sts_q, out_sts_d;
  logic [oal_pkg::POS_W-1:0] out_fnd_q, out_fnd_d;
  logic [oal_pkg::POS_W-1:0] out_cnt_q, out_cnt_d;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr;
  logic [oal_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

  logic          in_fire, out_free, scan_hit, drained;
  logic [CW-1:0] pos_ext, len_ext;
  logic          ins_bad, ins_full, del_bad;

  assign in_ready_o = (state_q == oal_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign pos_ext  = CW'(position_i);
  assign len_ext  = CW'(len_q);
  assign ins_bad  = (pos_ext == '0) || (pos_ext > len_ext + CW'(1));
  assign ins_full = (len_q == LW'(CAPACITY));
  assign del_bad  = (pos_ext == '0) || (pos_ext > len_ext);

  assign scan_hit = rd_pend_q && (ram_rdata == val_q);
  assign drained  = (rem_q == '0) && !rd_pend_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oal_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = oal_pkg::S_DONE;
          case (command_i)
            oal_pkg::CMD_INSERT: if (!ins_bad && !ins_full) state_d = oal_pkg::S_SHIFT;
            oal_pkg::CMD_DELETE: if (!del_bad) state_d = oal_pkg::S_SHIFT;
            oal_pkg::CMD_LOCATE: state_d = oal_pkg::S_SCAN;
            default:             state_d = oal_pkg::S_DONE;
          endcase
        end
      end
      oal_pkg::S_SHIFT: begin
        if (drained) begin
          state_d = (cmd_q == oal_pkg::CMD_INSERT) ? oal_pkg::S_PUT : oal_pkg::S_DONE;
        end
      end
      oal_pkg::S_PUT:  state_d = oal_pkg::S_DONE;
      oal_pkg::S_SCAN: if (scan_hit || drained) state_d = oal_pkg::S_DONE;
      oal_pkg::S_DONE: if (out_free) state_d = oal_pkg::S_IDLE;
      default:         state_d = oal_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_d       = cmd_q;
    sts_d       = sts_q;
    len_d       = len_q;
    rem_d       = rem_q;
    rd_pend_d   = rd_pend_q;
    rd_ptr_d    = rd_ptr_q;
    pend_addr_d = pend_addr_q;
    put_addr_d  = put_addr_q;
    val_d       = val_q;
    fnd_d       = fnd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sts_d   = out_sts_q;
    out_fnd_d   = out_fnd_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;

    unique case (state_q)
      oal_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_d     = oal_pkg::cmd_e'(command_i);
          val_d     = value_i;
          sts_d     = oal_pkg::ST_OK;
          fnd_d     = '0;
          rd_pend_d = 1'b0;
          case (command_i)
            oal_pkg::CMD_INSERT: begin
              if (ins_bad) begin
                sts_d = oal_pkg::ST_RANGE;
              end else if (ins_full) begin
                sts_d = oal_pkg::ST_FULL;
              end else begin
                // move entries pos-1 .. len-1 up by one, top first
                rem_d      = LW'(len_ext - pos_ext + CW'(1));
                rd_ptr_d   = AW'(len_ext - CW'(1));
                put_addr_d = AW'(pos_ext - CW'(1));
                len_d      = len_q + LW'(1);
              end
            end
            oal_pkg::CMD_DELETE: begin
              if (del_bad) begin
                sts_d = oal_pkg::ST_RANGE;
              end else begin
                // move entries pos .. len-1 down by one, bottom first
                rem_d    = LW'(len_ext - pos_ext);
                rd_ptr_d = AW'(pos_ext);
                len_d    = len_q - LW'(1);
              end
            end
            oal_pkg::CMD_LOCATE: begin
              rem_d    = len_q;
              rd_ptr_d = '0;
            end
            default: ;
          endcase
        end
      end
      oal_pkg::S_SHIFT: begin
        // write back last cycle's read while issuing the next one
        ram_we = rd_pend_q;
        if (rem_q != '0) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rem_d     = rem_q - LW'(1);
          if (cmd_q == oal_pkg::CMD_INSERT) begin
            pend_addr_d = rd_ptr_q + AW'(1);
            rd_ptr_d    = rd_ptr_q - AW'(1);
          end else begin
            pend_addr_d = rd_ptr_q - AW'(1);
            rd_ptr_d    = rd_ptr_q + AW'(1);
          end
        end else begin
          rd_pend_d = 1'b0;
        end
      end
      oal_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_addr_q;
        ram_wdata = val_q;
      end
      oal_pkg::S_SCAN: begin
        if (scan_hit) begin
          fnd_d     = oal_pkg::POS_W'(pend_addr_q) + oal_pkg::POS_W'(1);
          rd_pend_d = 1'b0;
        end else if (rem_q != '0) begin
          ram_re      = 1'b1;
          rd_pend_d   = 1'b1;
          pend_addr_d = rd_ptr_q;
          rd_ptr_d    = rd_ptr_q + AW'(1);
          rem_d       = rem_q - LW'(1);
        end else begin
          rd_pend_d = 1'b0;
        end
      end
      oal_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = sts_q;
          out_fnd_d   = fnd_q;
          out_cnt_d   = oal_pkg::POS_W'(len_q);
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oal_pkg::S_IDLE;
      len_q       <= '0;
      rem_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    sts_q       <= sts_d;
    rd_ptr_q    <= rd_ptr_d;
    pend_addr_q <= pend_addr_d;
    put_addr_q  <= put_addr_d;
    val_q       <= val_d;
    fnd_q       <= fnd_d;
    out_sts_q   <= out_sts_d;
    out_fnd_q   <= out_fnd_d;
    out_cnt_q   <= out_cnt_d;
  end

  oal_ram #(
    .WIDTH (oal_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_sts_q;
  assign found_position_o = out_fnd_q;
  assign count_o          = out_cnt_q;

  // Length never exceeds the store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length above capacity");

  // No read is in flight while a new command may enter.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_pend_q)
    else $error("read in flight while idle");

  // A shift write always carries data read on the previous cycle.
  a_shift_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oal_pkg::S_SHIFT && ram_we) |-> $past(ram_re))
    else $error("shift write without a preceding read");

  // An accepted valid insert grows the list by one.
  a_ins_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i == oal_pkg::CMD_INSERT && !ins_bad && !ins_full)
      |=> len_q == $past(len_q) + LW'(1))
    else $error("insert did not grow the list");

  // The result register is loaded only from the final state.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == oal_pkg::S_DONE)
    else $error("result loaded outside the final state");

endmodule

/* rtl/core/oal_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* test/tb_ordered_array_list.sv */
// Self-checking testbench for ordered_array_list: insert, delete and locate commands
// against an in-bench shadow list. Depends on oal_pkg and ordered_array_list.
`timescale 1ns / 1ps

module tb_ordered_array_list;

  localparam int unsigned LIST_CAPACITY  = 256;
  localparam int unsigned HOLDOFF_CYCLES = 700;   // well above the longest shift
  localparam int unsigned DRAIN_CYCLES   = 600;   // quiet tail after the last result
  localparam int unsigned CYCLE_LIMIT    = 1500000;

  // The block accepts code 3 and treats it as a no-op.
  localparam logic [oal_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [oal_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [oal_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic                             pause;   // marker: hold off until every result is back
    logic [oal_pkg::CMD_W-1:0]        cmd;
    logic [oal_pkg::POS_W-1:0]        pos;
    logic signed [oal_pkg::VAL_W-1:0] val;
  } list_word_t;

  typedef struct {
    oal_pkg::status_e          status;
    logic [oal_pkg::POS_W-1:0] found;
    logic [oal_pkg::POS_W-1:0] count;
  } list_result_t;

  logic                             clk_i            = 1'b0;
  logic                             rst_ni           = 1'b0;
  logic                             in_valid_i       = 1'b0;
  logic                             in_ready_o;
  logic [oal_pkg::CMD_W-1:0]        command_i        = '0;
  logic [oal_pkg::POS_W-1:0]        position_i       = '0;
  logic signed [oal_pkg::VAL_W-1:0] value_i          = '0;
  logic                             out_valid_o;
  logic                             out_ready_i      = 1'b0;
  logic [oal_pkg::STS_W-1:0]        status_o;
  logic [oal_pkg::POS_W-1:0]        found_position_o;
  logic [oal_pkg::POS_W-1:0]        count_o;

  ordered_array_list #(
    .CAPACITY(LIST_CAPACITY)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .count_o         (count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the list contents; index 0 is list position 1.
  logic signed [oal_pkg::VAL_W-1:0] list_entries[$];
  // Results owed by the block, oldest first.
  list_result_t                     results_due[$];
  // Words waiting to be offered, plus pause markers.
  list_word_t                       words_to_send[$];
  // Values handed to inserts, reused as locate keys so searches hit.
  logic signed [oal_pkg::VAL_W-1:0] inserted_vals[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned holdoff_req   = 0;
  int unsigned gen_len       = 0;   // list length as the generator sees it
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  logic        in_fire       = 1'b0;

  // Coverage tallies for the closing summary.
  int unsigned n_insert = 0, n_delete = 0, n_locate = 0, n_other = 0;
  int unsigned n_full = 0, n_range = 0, n_hits = 0, peak_len = 0, n_checked = 0;

  // Work out the result of one command and update the shadow list.
  function automatic list_result_t apply_list_command(logic [oal_pkg::CMD_W-1:0] cmd,
                                                      logic [oal_pkg::POS_W-1:0] pos,
                                                      logic signed [oal_pkg::VAL_W-1:0] val);
    list_result_t r;
    int unsigned  len;
    len      = list_entries.size();
    r.status = oal_pkg::ST_OK;
    r.found  = '0;
    case (cmd)
      oal_pkg::CMD_INSERT: begin
        n_insert++;
        // Position is checked before fullness.
        if (pos == 0 || pos > len + 1) begin
          r.status = oal_pkg::ST_RANGE;
        end else if (len >= LIST_CAPACITY) begin
          r.status = oal_pkg::ST_FULL;
        end else begin
          list_entries.insert(pos - 1, val);
        end
      end
      oal_pkg::CMD_DELETE: begin
        n_delete++;
        if (pos == 0 || pos > len) begin
          r.status = oal_pkg::ST_RANGE;
        end else begin
          list_entries.delete(pos - 1);
        end
      end
      oal_pkg::CMD_LOCATE: begin
        n_locate++;
        for (int i = 0; i < len; i++) begin
          if (list_entries[i] == val) begin
            r.found = oal_pkg::POS_W'(i + 1);
            n_hits++;
            break;
          end
        end
      end
      default: n_other++;
    endcase
    if (r.status == oal_pkg::ST_FULL) n_full++;
    if (r.status == oal_pkg::ST_RANGE) n_range++;
    if (list_entries.size() > peak_len) peak_len = list_entries.size();
    r.count = oal_pkg::POS_W'(list_entries.size());
    return r;
  endfunction

  // Sample both channels at the rising edge. Log each accepted word's expected result
  // first, then check whatever word leaves the block in the same cycle.
  always @(posedge clk_i) begin : watch_proc
    list_result_t exp_r;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      results_due.push_back(apply_list_command(command_i, position_i, value_i));
      words_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("result word with none outstanding: status %0d found %0d count %0d",
               status_o, found_position_o, count_o);
        mismatches++;
      end else begin
        exp_r = results_due.pop_front();
        n_checked++;
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatches++;
        end
        if (found_position_o !== exp_r.found) begin
          $error("found_position: expected %0d, got %0d", exp_r.found, found_position_o);
          mismatches++;
        end
        if (count_o !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count_o);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("[ordered_array_list] ERROR");
      $finish;
    end
  end

  // Input driver: hold a word until it is taken, then pick the next one at the falling
  // edge. A pause marker keeps valid low until the block has returned everything.
  always @(negedge clk_i) begin : drive_proc
    list_word_t w;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (words_to_send.size() != 0 && words_to_send[0].pause) begin
        if (results_due.size() == 0) void'(words_to_send.pop_front());
        in_valid_i <= 1'b0;
      end else if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= w.cmd;
        position_i <= w.pos;
        value_i    <= w.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, or a long hold-off each time one is requested.
  always @(negedge clk_i) begin : sink_proc
    int unsigned holdoff_seen;
    int unsigned holdoff_left;
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Queue one word and advance the generator's view of the list length.
  task automatic queue_word(logic [oal_pkg::CMD_W-1:0] cmd, logic [oal_pkg::POS_W-1:0] pos,
                            logic signed [oal_pkg::VAL_W-1:0] val);
    list_word_t w;
    w.pause = 1'b0;
    w.cmd   = cmd;
    w.pos   = pos;
    w.val   = val;
    words_to_send.push_back(w);
    words_queued++;
    if (cmd == oal_pkg::CMD_INSERT && pos != 0 && pos <= gen_len + 1 &&
        gen_len < LIST_CAPACITY) begin
      gen_len++;
    end else if (cmd == oal_pkg::CMD_DELETE && pos != 0 && pos <= gen_len) begin
      gen_len--;
    end
  endtask

  task automatic queue_pause();
    list_word_t w;
    w.pause = 1'b1;
    w.cmd   = oal_pkg::CMD_LOCATE;
    w.pos   = '0;
    w.val   = '0;
    words_to_send.push_back(w);
  endtask

  // Small values four times in ten so duplicates show up, some corners, the rest full-range.
  function automatic logic signed [oal_pkg::VAL_W-1:0] pick_value();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = int'($urandom_range(7)) - 4;
        return v;
      end
      4: begin
        case ($urandom_range(3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mixed traffic: positions mostly legal for the current length, some noise anywhere.
  task automatic queue_random(int unsigned n);
    int unsigned                      roll;
    logic [oal_pkg::CMD_W-1:0]        cmd;
    logic [oal_pkg::POS_W-1:0]        pos;
    logic signed [oal_pkg::VAL_W-1:0] val;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(39) == 0) queue_pause();
      roll = $urandom_range(99);
      if (roll < 45) cmd = oal_pkg::CMD_INSERT;
      else if (roll < 75) cmd = oal_pkg::CMD_DELETE;
      else if (roll < 97) cmd = oal_pkg::CMD_LOCATE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(9) == 0) begin
        pos = oal_pkg::POS_W'($urandom_range(511));
      end else if (cmd == oal_pkg::CMD_INSERT) begin
        pos = oal_pkg::POS_W'($urandom_range(gen_len + 1, 1));
      end else if (cmd == oal_pkg::CMD_DELETE && gen_len > 0) begin
        pos = oal_pkg::POS_W'($urandom_range(gen_len, 1));
      end else begin
        pos = oal_pkg::POS_W'($urandom_range(511));
      end
      if (cmd == oal_pkg::CMD_LOCATE && inserted_vals.size() != 0 &&
          $urandom_range(9) < 6) begin
        val = inserted_vals[$urandom_range(inserted_vals.size() - 1)];
      end else begin
        val = pick_value();
      end
      if (cmd == oal_pkg::CMD_INSERT) begin
        inserted_vals.push_back(val);
        if (inserted_vals.size() > 32) void'(inserted_vals.pop_front());
      end
      queue_word(cmd, pos, val);
    end
  endtask

  // Wait at falling edges, when the rising-edge bookkeeping has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_taken != words_queued || results_due.size() != 0);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list errors, corner values, head/tail/middle edits, first-match
    // search with duplicates, ignored locate position and the unused command code.
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   32'sd5);
    queue_word(oal_pkg::CMD_DELETE, 9'd1,   32'sd0);
    queue_word(oal_pkg::CMD_INSERT, 9'd0,   32'sd1);
    queue_word(oal_pkg::CMD_INSERT, 9'd2,   32'sd1);
    queue_word(oal_pkg::CMD_INSERT, 9'd1,   VAL_MIN);
    queue_word(oal_pkg::CMD_INSERT, 9'd2,   VAL_MAX);
    queue_word(oal_pkg::CMD_INSERT, 9'd1,   32'sd0);
    queue_word(oal_pkg::CMD_INSERT, 9'd4,   -32'sd1);
    queue_word(oal_pkg::CMD_INSERT, 9'd3,   VAL_MIN);
    queue_word(oal_pkg::CMD_INSERT, 9'd511, 32'sd7);
    queue_word(oal_pkg::CMD_LOCATE, 9'd511, VAL_MIN);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   VAL_MAX);
    queue_word(oal_pkg::CMD_LOCATE, 9'd3,   -32'sd1);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   32'sd0);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   32'sd12345);
    queue_word(CMD_UNUSED,          9'd511, -32'sd1);
    queue_word(oal_pkg::CMD_DELETE, 9'd0,   32'sd0);
    queue_word(oal_pkg::CMD_DELETE, 9'd6,   32'sd0);
    queue_word(oal_pkg::CMD_DELETE, 9'd5,   32'sd0);
    queue_word(oal_pkg::CMD_DELETE, 9'd1,   32'sd0);
    queue_word(oal_pkg::CMD_DELETE, 9'd511, 32'sd0);
    queue_word(oal_pkg::CMD_INSERT, 9'd2,   32'sh5555_5555);
    queue_word(oal_pkg::CMD_LOCATE, 9'd1,   32'sh5555_5555);
    wait_drained();

    // Back-to-back traffic with no idling on either side.
    queue_random(120);
    wait_drained();

    // Sparse sender.
    send_idle_pct = 80;
    queue_random(90);
    wait_drained();

    // Slow receiver.
    send_idle_pct = 0;
    stall_pct     = 80;
    queue_random(90);
    wait_drained();

    // Both sides idle a third of the time: fill the list to capacity, hit the full and
    // range checks at the top end, then edit and search the full list.
    send_idle_pct = 33;
    stall_pct     = 33;
    while (gen_len < LIST_CAPACITY) begin
      queue_word(oal_pkg::CMD_INSERT, oal_pkg::POS_W'($urandom_range(gen_len + 1, 1)),
                 pick_value());
    end
    queue_word(oal_pkg::CMD_INSERT, 9'd1,   32'sd9);
    queue_word(oal_pkg::CMD_INSERT, 9'd257, 32'sd9);
    queue_word(oal_pkg::CMD_INSERT, 9'd258, 32'sd9);
    queue_word(oal_pkg::CMD_INSERT, 9'd0,   32'sd9);
    queue_word(oal_pkg::CMD_INSERT, 9'd511, 32'sd9);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   32'sh1234_5678);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   VAL_MIN);
    queue_word(oal_pkg::CMD_DELETE, 9'd257, 32'sd0);
    queue_word(oal_pkg::CMD_DELETE, 9'd256, 32'sd0);
    queue_word(oal_pkg::CMD_INSERT, 9'd256, VAL_MAX);
    queue_word(oal_pkg::CMD_LOCATE, 9'd0,   VAL_MAX);
    queue_word(oal_pkg::CMD_DELETE, 9'd1,   32'sd0);
    queue_random(60);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering words, so the block
    // parks one result, takes the next command and then back-pressures its input.
    send_idle_pct = 0;
    stall_pct     = 0;
    holdoff_req++;
    queue_random(40);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("ran %0d commands: %0d insert, %0d delete, %0d locate, %0d no-op; %0d checked",
             words_taken, n_insert, n_delete, n_locate, n_other, n_checked);
    $display("list peaked at %0d of %0d entries; %0d full, %0d range errors, %0d locate hits",
             peak_len, LIST_CAPACITY, n_full, n_range, n_hits);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[ordered_array_list] OK");
    end else begin
      $display("[ordered_array_list] ERROR");
    end
    $finish;
  end

endmodule
